>>> hdl/heightmap_bilinear_sampler_macros.svh
// ---------------------------------------------------------------------------
// Heightmap bilinear sampler assertion macros
// Shared concurrent assertion forms clocked on i_clk, reset on i_rst_n.
// ---------------------------------------------------------------------------
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH

// Condition must never hold
`define HBS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define HBS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define HBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/hbs_pkg.sv
// ---------------------------------------------------------------------------
// Heightmap bilinear sampler package
// Shared constants, codes, types and helper functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package hbs_pkg;

    localparam int MAX_SIDE    = 256;
    localparam int SIDE_W      = $clog2(MAX_SIDE) + 1;
    localparam int CELL_W      = $clog2(MAX_SIDE);
    localparam int ADDR_W      = 2 * CELL_W;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = Q_PTR_W + 1;
    localparam int CFG_IDX_W   = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_W    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_H    = 3'd4;

    // Opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;
    localparam logic [16:0] ONE_Q16   = 17'h1_0000;

    typedef struct packed {
        logic [31:0]       origin_x;
        logic [31:0]       origin_z;
        logic [31:0]       inv_cell;
        logic [SIDE_W-1:0] grid_w;
        logic [SIDE_W-1:0] grid_h;
    } t_cfg;

    // One classified beat between the front and the back
    typedef struct packed {
        logic              op;
        logic              found;
        logic [ADDR_W-1:0] a00;
        logic [ADDR_W-1:0] a01;
        logic [ADDR_W-1:0] a10;
        logic [ADDR_W-1:0] a11;
        logic [15:0]       fx;
        logic [15:0]       fz;
        logic [31:0]       wdata;
    } t_qent;

    typedef struct packed {
        logic   valid;
        t_qent  ent;
    } t_push;

    // Saturate a grid side into [2, MAX_SIDE]
    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v < SIDE_W'(2)) begin
            r = SIDE_W'(2);
        end else if (v > SIDE_W'(MAX_SIDE)) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/hbs_front.sv
// ---------------------------------------------------------------------------
// Heightmap sampler front end
// Offsets, grid scaling and classification of each beat into store addresses.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hbs_front import hbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_adv,
    input  logic        i_valid,
    input  logic        i_opcode,
    input  logic [15:0] i_write_index,
    input  logic [31:0] i_write_height,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_z,
    output t_push       o_push
);

    logic        r1_valid, r1_op;
    logic [15:0] r1_widx;
    logic [31:0] r1_wh;
    logic [32:0] r1_offx, r1_offz;

    logic        r2_valid, r2_op, r2_negx, r2_negz;
    logic [15:0] r2_widx;
    logic [31:0] r2_wh;
    logic [63:0] r2_gx, r2_gz;

    // Control stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    // Subtract origin, then scale by the reciprocal cell size
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_op   <= i_opcode;
            r1_widx <= i_write_index;
            r1_wh   <= i_write_height;
            r1_offx <= {i_pos_x[31], i_pos_x} - {i_cfg.origin_x[31], i_cfg.origin_x};
            r1_offz <= {i_pos_z[31], i_pos_z} - {i_cfg.origin_z[31], i_cfg.origin_z};
            r2_op   <= r1_op;
            r2_widx <= r1_widx;
            r2_wh   <= r1_wh;
            r2_negx <= r1_offx[32];
            r2_negz <= r1_offz[32];
            r2_gx   <= {32'd0, r1_offx[31:0]} * {32'd0, i_cfg.inv_cell};
            r2_gz   <= {32'd0, r1_offz[31:0]} * {32'd0, i_cfg.inv_cell};
        end
    end

    // Classify: bounds, clamped neighbors, linear addresses
    logic [SIDE_W-1:0] w, h, cx_p1, cz_p1, cx1_s, cz1_s;
    logic [CELL_W-1:0] cx, cz, cx1, cz1;
    logic              in_x, in_z;
    logic [16:0]       row0, row1;
    logic [16:0]       s00, s01, s10, s11;
    t_qent             ent;

    always_comb begin
        w     = eff_side(i_cfg.grid_w);
        h     = eff_side(i_cfg.grid_h);
        in_x  = !r2_negx && (r2_gx[63:32] < {{(32-SIDE_W){1'b0}}, w});
        in_z  = !r2_negz && (r2_gz[63:32] < {{(32-SIDE_W){1'b0}}, h});
        cx    = r2_gx[32 +: CELL_W];
        cz    = r2_gz[32 +: CELL_W];
        cx_p1 = {1'b0, cx} + SIDE_W'(1);
        cz_p1 = {1'b0, cz} + SIDE_W'(1);
        cx1_s = (cx_p1 < w) ? cx_p1 : (w - SIDE_W'(1));
        cz1_s = (cz_p1 < h) ? cz_p1 : (h - SIDE_W'(1));
        cx1   = cx1_s[CELL_W-1:0];
        cz1   = cz1_s[CELL_W-1:0];
        row0  = 17'({{(17-CELL_W){1'b0}}, cz} * {{(17-SIDE_W){1'b0}}, w});
        row1  = (cz1 != cz) ? (row0 + {{(17-SIDE_W){1'b0}}, w}) : row0;
        s00   = row0 + {{(17-CELL_W){1'b0}}, cx};
        s01   = row0 + {{(17-CELL_W){1'b0}}, cx1};
        s10   = row1 + {{(17-CELL_W){1'b0}}, cx};
        s11   = row1 + {{(17-CELL_W){1'b0}}, cx1};

        ent.op    = r2_op;
        ent.found = in_x && in_z;
        ent.a00   = (r2_op == OP_WRITE) ? r2_widx : s00[ADDR_W-1:0];
        ent.a01   = s01[ADDR_W-1:0];
        ent.a10   = s10[ADDR_W-1:0];
        ent.a11   = s11[ADDR_W-1:0];
        ent.fx    = r2_gx[31:16];
        ent.fz    = r2_gz[31:16];
        ent.wdata = r2_wh;

        o_push.valid = r2_valid;
        o_push.ent   = ent;
    end

endmodule
`default_nettype wire

>>> hdl/hbs_queue.sv
// ---------------------------------------------------------------------------
// Heightmap sampler decoupling queue
// Small FIFO of classified beats between the front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "heightmap_bilinear_sampler_macros.svh"
module hbs_queue import hbs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_nempty,
    output t_qent o_head
);

    t_qent              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               push, pop;

    assign o_full   = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_nempty = (r_count != '0);
    assign push     = i_push.valid && !o_full;
    assign pop      = i_pop && o_nempty;
    assign o_head   = r_mem[r_rptr];

    // Track fill level
    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (push) r_wptr <= r_wptr + Q_PTR_W'(1);
            if (pop)  r_rptr <= r_rptr + Q_PTR_W'(1);
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wptr] <= i_push.ent;
    end

    `HBS_ASSERT_NEVER(a_no_overflow, r_count > Q_CNT_W'(Q_DEPTH), "queue overflow")
    `HBS_ASSERT_NEVER(a_no_underflow, i_pop && !o_nempty, "queue underflow pop")
    `HBS_ASSERT_NEXT(a_count_track, push && !pop, r_count == $past(r_count) + 1'b1, "count lost")
    `HBS_ASSERT_NEVER(a_ptr_gap, r_count == '0 && r_wptr != r_rptr, "pointers split when empty")

endmodule
`default_nettype wire

>>> hdl/hbs_back.sv
// ---------------------------------------------------------------------------
// Heightmap sampler back end
// Height store, four-corner fetch, bilinear blend and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "heightmap_bilinear_sampler_macros.svh"
module hbs_back import hbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qent       i_head,
    input  logic        i_nempty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_height_out,
    output logic        o_found
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;

    // Two copies, each read at two addresses
    logic [31:0] r_mem_a [DEPTH];
    logic [31:0] r_mem_b [DEPTH];

    logic        adv;
    logic        r1_valid, r1_op, r1_found;
    logic [31:0] r1_h00, r1_h01, r1_h10, r1_h11;
    logic [32:0] r1_w00, r1_w01, r1_w10, r1_w11;
    logic        r2_valid, r2_found;
    logic [63:0] r2_p00, r2_p01, r2_p10, r2_p11;
    logic        r_out_valid;
    logic [16:0] gx, gz, fx, fz;
    logic [63:0] sum;

    assign adv   = !r_out_valid || i_ready;
    assign o_pop = adv && i_nempty;
    assign o_valid = r_out_valid;

    assign fx = {1'b0, i_head.fx};
    assign fz = {1'b0, i_head.fz};
    assign gx = ONE_Q16 - fx;
    assign gz = ONE_Q16 - fz;

    // Control stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r1_valid    <= i_nempty;
            r2_valid    <= r1_valid && (r1_op == OP_SAMPLE);
            r_out_valid <= r2_valid;
        end
    end

    // Write the store, fetch corners, form weights
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (i_nempty && (i_head.op == OP_WRITE)) begin
                r_mem_a[i_head.a00] <= i_head.wdata;
                r_mem_b[i_head.a00] <= i_head.wdata;
            end
            r1_h00   <= r_mem_a[i_head.a00];
            r1_h01   <= r_mem_a[i_head.a01];
            r1_h10   <= r_mem_b[i_head.a10];
            r1_h11   <= r_mem_b[i_head.a11];
            r1_op    <= i_head.op;
            r1_found <= i_head.found;
            r1_w00   <= 33'({17'd0, gx} * {17'd0, gz});
            r1_w01   <= 33'({17'd0, fx} * {17'd0, gz});
            r1_w10   <= 33'({17'd0, gx} * {17'd0, fz});
            r1_w11   <= 33'({17'd0, fx} * {17'd0, fz});
        end
    end

    // Weight the biased heights
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_found <= r1_found;
            r2_p00   <= {32'd0, r1_h00 ^ SIGN_BIAS} * {31'd0, r1_w00};
            r2_p01   <= {32'd0, r1_h01 ^ SIGN_BIAS} * {31'd0, r1_w01};
            r2_p10   <= {32'd0, r1_h10 ^ SIGN_BIAS} * {31'd0, r1_w10};
            r2_p11   <= {32'd0, r1_h11 ^ SIGN_BIAS} * {31'd0, r1_w11};
        end
    end

    // Sum, round half up, remove bias
    assign sum = r2_p00 + r2_p01 + r2_p10 + r2_p11 + 64'h8000_0000;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_found      <= r2_found;
            o_height_out <= r2_found ? (sum[63:32] ^ SIGN_BIAS) : 32'd0;
        end
    end

    `HBS_ASSERT_IMPLY(a_miss_zero, o_valid && !o_found, o_height_out == 32'd0, "miss not zero")
    `HBS_ASSERT_NEXT(a_hold_stall, o_valid && !i_ready, o_valid && $stable(o_height_out), "lost beat")

endmodule
`default_nettype wire

>>> hdl/heightmap_bilinear_sampler.sv
// ---------------------------------------------------------------------------
// Heightmap bilinear sampler
// Height store with bilinear sampling of world positions, Q16.16.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one beat per cycle while o_ready
//   is high. Opcode write stores i_write_height at i_write_index and gives
//   no result; opcode sample maps (i_pos_x, i_pos_z) into the grid and
//   returns one result on o_valid/i_ready with o_height_out and o_found.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_wdata while
//   the block is idle; writes take effect at once.
//   Throughput: one beat per cycle while the output is not stalled, set by
//   the two-copy height store that serves four corner reads each cycle.
//   A later sample always sees every earlier write.
//   Reset clears all control state and restores register defaults; store
//   contents stay undefined until written.
//   When the receiver stalls the back end holds, the 4-entry queue fills,
//   and o_ready drops once it is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module heightmap_bilinear_sampler import hbs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_opcode,
    input  logic [15:0]          i_write_index,
    input  logic [31:0]          i_write_height,
    input  logic [31:0]          i_pos_x,
    input  logic [31:0]          i_pos_z,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_height_out,
    output logic                 o_found
);

    t_cfg  r_cfg;
    t_push push;
    t_qent head;
    logic  q_full, q_nempty, pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= 32'd0;
            r_cfg.origin_z <= 32'd0;
            r_cfg.inv_cell <= 32'd65536;
            r_cfg.grid_w   <= SIDE_W'(MAX_SIDE);
            r_cfg.grid_h   <= SIDE_W'(MAX_SIDE);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_X: r_cfg.origin_x <= i_cfg_wdata;
                CFG_ORIGIN_Z: r_cfg.origin_z <= i_cfg_wdata;
                CFG_INV_CELL: r_cfg.inv_cell <= i_cfg_wdata;
                CFG_GRID_W:   r_cfg.grid_w   <= i_cfg_wdata[SIDE_W-1:0];
                CFG_GRID_H:   r_cfg.grid_h   <= i_cfg_wdata[SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_ready = !q_full;

    hbs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_adv          (!q_full),
        .i_valid        (i_valid),
        .i_opcode       (i_opcode),
        .i_write_index  (i_write_index),
        .i_write_height (i_write_height),
        .i_pos_x        (i_pos_x),
        .i_pos_z        (i_pos_z),
        .o_push         (push)
    );

    hbs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_nempty (q_nempty),
        .o_head   (head)
    );

    hbs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_nempty     (q_nempty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_height_out (o_height_out),
        .o_found      (o_found)
    );

endmodule
`default_nettype wire

>>> tb/heightmap_bilinear_sampler_tb.sv
// ---------------------------------------------------------------------------
// Heightmap bilinear sampler testbench
// Drives height writes and position samples through several grid settings.
// A scoreboard with its own height store and register copy predicts each
// sample result and checks the output beats in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module heightmap_bilinear_sampler_tb;
    import hbs_pkg::*;

    typedef struct {
        logic [31:0] height;
        logic        found;
    } t_sample_res;

    class height_scoreboard;
        logic [31:0]       org_x, org_z, inv_cell;
        logic [8:0]        grid_w, grid_h;
        logic [31:0]       heights [int];
        t_sample_res       pending_q [$];
        int                errors;

        function new();
            org_x = '0;
            org_z = '0;
            inv_cell = 32'd65536;
            grid_w = 9'd256;
            grid_h = 9'd256;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_ORIGIN_X: org_x = val;
                CFG_ORIGIN_Z: org_z = val;
                CFG_INV_CELL: inv_cell = val;
                CFG_GRID_W:   grid_w = val[8:0];
                CFG_GRID_H:   grid_h = val[8:0];
                default: ;
            endcase
        endfunction

        function int side_used(logic [8:0] v);
            if (v < 9'd2) return 2;
            if (v > 9'(MAX_SIDE)) return MAX_SIDE;
            return int'(v);
        endfunction

        // Map one world coordinate to cell and fraction; 0 when outside
        function bit axis_map(logic [31:0] pos, logic [31:0] org, int side,
                              output int cell_idx, output int frac);
            logic signed [33:0] off;
            logic [65:0]        g;
            off = $signed({{2{pos[31]}}, pos}) - $signed({{2{org[31]}}, org});
            cell_idx = 0;
            frac = 0;
            if (off < 0) return 0;
            g = 66'(off[32:0]) * 66'(inv_cell);
            if (g[65:32] >= 34'(side)) return 0;
            cell_idx = int'(g[63:32]);
            frac = int'(g[31:16]);
            return 1;
        endfunction

        // Corner addresses in the order 00, 01, 10, 11
        function bit corners(logic [31:0] px, logic [31:0] pz,
                             output int addr [4], output int fx, output int fz);
            int w, h, cx, cz, cx1, cz1;
            w = side_used(grid_w);
            h = side_used(grid_h);
            addr = '{0, 0, 0, 0};
            fz = 0;
            if (!axis_map(px, org_x, w, cx, fx)) return 0;
            if (!axis_map(pz, org_z, h, cz, fz)) return 0;
            cx1 = (cx + 1 < w) ? cx + 1 : w - 1;
            cz1 = (cz + 1 < h) ? cz + 1 : h - 1;
            addr = '{cz * w + cx, cz * w + cx1, cz1 * w + cx, cz1 * w + cx1};
            return 1;
        endfunction

        function logic [31:0] read_height(int a);
            return heights.exists(a) ? heights[a] : 32'd0;
        endfunction

        // Note one accepted input beat and queue its result, if any
        function void note_beat(logic op, logic [15:0] idx, logic [31:0] wh,
                                logic [31:0] px, logic [31:0] pz);
            int          addr [4];
            int          fx, fz;
            logic [65:0] acc;
            logic [33:0] wgt [4];
            t_sample_res r;
            if (op == OP_WRITE) begin
                heights[int'(idx)] = wh;
                return;
            end
            r.height = '0;
            r.found = 1'b0;
            if (corners(px, pz, addr, fx, fz)) begin
                wgt[0] = 34'(65536 - fx) * 34'(65536 - fz);
                wgt[1] = 34'(fx) * 34'(65536 - fz);
                wgt[2] = 34'(65536 - fx) * 34'(fz);
                wgt[3] = 34'(fx) * 34'(fz);
                acc = '0;
                for (int k = 0; k < 4; k++) begin
                    acc += 66'(read_height(addr[k]) ^ SIGN_BIAS) * 66'(wgt[k]);
                end
                acc = (acc + 66'h8000_0000) >> 32;
                r.height = acc[31:0] ^ SIGN_BIAS;
                r.found = 1'b1;
            end
            pending_q.insert(pending_q.size(), r);
        endfunction

        function void check_result(logic [31:0] height, logic found);
            t_sample_res e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result height=%h found=%b", $time, height, found);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (found !== e.found) begin
                $display("%0t: found expected %b actual %b", $time, e.found, found);
                errors++;
            end
            if (height !== e.height) begin
                $display("%0t: height_out expected %h actual %h", $time, e.height, height);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]          i_cfg_wdata;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_opcode;
    logic [15:0]          i_write_index;
    logic [31:0]          i_write_height;
    logic [31:0]          i_pos_x;
    logic [31:0]          i_pos_z;
    logic                 o_valid;
    logic                 i_ready;
    logic [31:0]          o_height_out;
    logic                 o_found;

    heightmap_bilinear_sampler uut (.*);

    height_scoreboard sb = new();
    bit               written [int];
    bit               beat_taken;
    bit               long_hold;
    int               burst_left;
    int               stall_mode;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Input and output monitors
    always @(posedge i_clk) begin
        beat_taken = i_rst_n && i_valid && o_ready;
        if (beat_taken) begin
            sb.note_beat(i_opcode, i_write_index, i_write_height, i_pos_x, i_pos_z);
        end
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_height_out, o_found);
        end
    end

    // Receiver stall pattern, with one long hold-off on request
    initial begin
        int hold_cnt;
        i_ready = 1'b0;
        stall_mode = 0;
        hold_cnt = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold && hold_cnt == 0) begin
                hold_cnt = 300;
                long_hold = 1'b0;
            end
            if ($urandom_range(0, 63) == 0) begin
                stall_mode = $urandom_range(0, 2);
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_ready = 1'b0;
            end else begin
                case (stall_mode)
                    0: i_ready = 1'b1;
                    1: i_ready = 1'($urandom_range(0, 1));
                    default: i_ready = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Offer one beat; bursts of random length with random gaps between them
    task automatic send_beat(logic op, logic [15:0] idx, logic [31:0] wh,
                             logic [31:0] px, logic [31:0] pz);
        if (burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid = 1'b1;
        i_opcode = op;
        i_write_index = idx;
        i_write_height = wh;
        i_pos_x = px;
        i_pos_z = pz;
        do @(negedge i_clk); while (!beat_taken);
    endtask

    task automatic write_height(int addr, logic [31:0] h);
        send_beat(OP_WRITE, 16'(addr), h, $urandom, $urandom);
        written[addr] = 1'b1;
    endtask

    // Fill any unwritten corner first so the sample never reads stale store
    task automatic sample_at(logic [31:0] px, logic [31:0] pz);
        int addr [4];
        int fx, fz;
        if (sb.corners(px, pz, addr, fx, fz)) begin
            foreach (addr[k]) begin
                if (!written.exists(addr[k])) write_height(addr[k], $urandom);
            end
        end
        send_beat(OP_SAMPLE, 16'($urandom), $urandom, px, pz);
    endtask

    task automatic wait_idle();
        i_valid = 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic setup_grid(logic [31:0] ox, logic [31:0] oz, logic [31:0] inv,
                              logic [31:0] gw, logic [31:0] gh);
        wait_idle();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_INV_CELL, inv);
        write_reg(CFG_GRID_W, gw);
        write_reg(CFG_GRID_H, gh);
    endtask

    // World offset with a wide spread of magnitudes, sometimes negative
    function automatic logic [31:0] near_offset();
        logic [31:0] v;
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 9) == 0) v = -v;
        return v;
    endfunction

    task automatic random_items(int n);
        int w, h;
        for (int i = 0; i < n; i++) begin
            w = sb.side_used(sb.grid_w);
            h = sb.side_used(sb.grid_h);
            case ($urandom_range(0, 9))
                0: send_beat(OP_WRITE, 16'($urandom), $urandom, $urandom, $urandom);
                1: write_height($urandom_range(0, w * h - 1), $urandom);
                2: sample_at($urandom, $urandom);
                default: sample_at(sb.org_x + near_offset(), sb.org_z + near_offset());
            endcase
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ORIGIN_X;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_opcode = OP_WRITE;
        i_write_index = '0;
        i_write_height = '0;
        i_pos_x = '0;
        i_pos_z = '0;
        long_hold = 1'b0;
        burst_left = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset settings: exact vertex, extreme heights, clamping and outside cases
        write_height(0, 32'h7FFF_FFFF);
        write_height(1, 32'h8000_0000);
        write_height(256, 32'h0000_0000);
        write_height(257, 32'hFFFF_FFFF);
        write_height(16'hFFFF, 32'h1234_5678);
        sample_at(32'h0, 32'h0);
        sample_at(32'h0000_8000, 32'h0);
        sample_at(32'h0000_8000, 32'h0000_8000);
        sample_at(32'h0000_0001, 32'h0000_FFFF);
        sample_at(32'h00FF_0000, 32'h00FF_0000);
        sample_at(32'h00FF_8000, 32'h00FF_C000);
        sample_at(32'h0100_0000, 32'h0);
        sample_at(32'h0, 32'h0100_0000);
        sample_at(32'hFFFF_FFFF, 32'h0);
        sample_at(32'h0, 32'h8000_0000);
        sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        long_hold = 1'b1;
        random_items(170);

        // Tiny grid at extreme origins
        setup_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'd65536, 32'd3, 32'd2);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);
        sample_at(32'h8002_8000, 32'h7FFF_FFFF);
        sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_items(200);

        // Sides below range saturate to two, zero scale maps to vertex zero
        setup_grid(32'h0001_0000, 32'hFFFF_0000, 32'd0, 32'd0, 32'd1);
        sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        sample_at(32'h0000_FFFF, 32'h0);
        random_items(150);

        // Sides above range saturate, widest scale
        setup_grid($urandom, $urandom, 32'hFFFF_FFFF, 32'h1FF, 32'd300);
        random_items(200);

        // Odd width, two-unit cells
        setup_grid(32'hFFF0_0000, 32'h0010_0000, 32'h0000_8000, 32'd17, 32'd200);
        random_items(160);

        // Single row strip, third-unit cells
        setup_grid(32'h0, 32'h0, 32'h0003_0000, 32'd256, 32'd2);
        random_items(160);

        wait_idle();
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("heightmap_bilinear_sampler verification clean");
        end else begin
            $display("heightmap_bilinear_sampler verification failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("heightmap_bilinear_sampler verification failed");
        $finish;
    end
endmodule
`default_nettype wire
